// ===== rtl/lfu_cache_with_lru_tiebreak_macros.svh =====
// Assertion macros used by the checker file of the LFU cache.
`ifndef LFU_CACHE_WITH_LRU_TIEBREAK_MACROS_SVH
`define LFU_CACHE_WITH_LRU_TIEBREAK_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LFU_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LFU_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/lfu_pkg.sv =====
// Shared constants and controller/datapath interface types of the LFU cache.
package lfu_pkg;

  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned KeyW          = 32;
  localparam int unsigned ValW          = 32;
  localparam int unsigned CntW          = 32;
  localparam int unsigned TouchW        = 32;
  localparam int unsigned CapW          = 5;
  localparam int unsigned ApbDataW      = 32;
  localparam int unsigned ApbAddrW      = 3;

  // Register index, taken from paddr[2]
  localparam logic CfgCapacity = 1'b0;
  localparam logic [CapW-1:0] CapacityRst = 5'd16;

  typedef struct packed {
    logic load;    // latch request, clear scan results
    logic step;    // issue the next entry read
    logic commit;  // update the store and load the result register
  } lfu_cmd_t;

  typedef struct packed {
    logic cap_zero;   // capacity register is zero
    logic scan_last;  // read of the last entry is being issued
  } lfu_status_t;

endpackage

// ===== rtl/lfu_ctrl.sv =====
// Sequencer of the LFU cache: accept, scan, commit and result handshake.
module lfu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  lfu_pkg::lfu_status_t status_i,
  output lfu_pkg::lfu_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StLast,
    StCommit
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_take;
  logic   out_free;

  assign in_stall_o  = (state_q != StIdle);
  assign in_take     = in_valid_i && (state_q == StIdle);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = in_take;
    cmd_o.step   = (state_q == StScan);
    cmd_o.commit = (state_q == StCommit) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      // Load a new result or drop the one just taken
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_take) begin
            state_q <= status_i.cap_zero ? StCommit : StScan;
          end
        end
        StScan: begin
          if (status_i.scan_last) begin
            state_q <= StLast;
          end
        end
        StLast: begin
          state_q <= StCommit;
        end
        StCommit: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// ===== rtl/lfu_dp.sv =====
// Datapath of the LFU cache: entry memories, scan compare and result register.
module lfu_dp #(
  parameter int unsigned MAX_ENTRIES = lfu_pkg::MaxEntriesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lfu_pkg::lfu_cmd_t          cmd_i,
  output lfu_pkg::lfu_status_t       status_o,
  input  logic [lfu_pkg::CapW-1:0]   capacity_i,
  input  logic                       action_i,
  input  logic [lfu_pkg::KeyW-1:0]   req_key_i,
  input  logic [lfu_pkg::ValW-1:0]   req_value_i,
  output logic                       hit_o,
  output logic [lfu_pkg::ValW-1:0]   read_value_o,
  output logic                       evicted_o,
  output logic [lfu_pkg::KeyW-1:0]   evicted_key_o
);

  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned OccW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW = (OccW > lfu_pkg::CapW) ? OccW : lfu_pkg::CapW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_ENTRIES - 1);

  // Entry stores
  logic [lfu_pkg::KeyW-1:0]   key_mem [MAX_ENTRIES];
  logic [lfu_pkg::ValW-1:0]   val_mem [MAX_ENTRIES];
  logic [lfu_pkg::CntW-1:0]   cnt_mem [MAX_ENTRIES];
  logic [lfu_pkg::TouchW-1:0] tch_mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]     valid_q;
  logic [lfu_pkg::TouchW-1:0] tclk_q;

  // Latched request
  logic                     is_put_q;
  logic [lfu_pkg::KeyW-1:0] key_q;
  logic [lfu_pkg::ValW-1:0] val_q;

  // Read stage
  logic [IdxW-1:0]            addr_q;
  logic                       cmp_en_q;
  logic [IdxW-1:0]            cmp_idx_q;
  logic                       rd_vld_q;
  logic [lfu_pkg::KeyW-1:0]   rd_key_q;
  logic [lfu_pkg::ValW-1:0]   rd_val_q;
  logic [lfu_pkg::CntW-1:0]   rd_cnt_q;
  logic [lfu_pkg::TouchW-1:0] rd_tch_q;

  // Scan results
  logic                       found_q;
  logic [IdxW-1:0]            found_idx_q;
  logic [lfu_pkg::ValW-1:0]   found_val_q;
  logic [lfu_pkg::CntW-1:0]   found_cnt_q;
  logic                       vic_q;
  logic [IdxW-1:0]            vic_idx_q;
  logic [lfu_pkg::KeyW-1:0]   vic_key_q;
  logic [lfu_pkg::CntW-1:0]   vic_cnt_q;
  logic [lfu_pkg::TouchW-1:0] vic_age_q;
  logic                       free_q;
  logic [IdxW-1:0]            free_idx_q;
  logic [OccW-1:0]            occ_q;

  logic [lfu_pkg::TouchW-1:0] rd_age;
  logic                       key_match;
  logic                       vic_take;
  logic [CmpW-1:0]            cap_eff;
  logic                       full;
  logic                       active;
  logic                       do_evict;
  logic                       do_ins;
  logic                       do_wr;
  logic [IdxW-1:0]            wr_idx;
  logic [lfu_pkg::CntW-1:0]   cnt_inc;

  assign status_o.cap_zero  = (capacity_i == '0);
  assign status_o.scan_last = cmd_i.step && (addr_q == LastIdx);

  assign rd_age    = tclk_q - rd_tch_q;
  assign key_match = (rd_key_q == key_q);
  assign vic_take  = !vic_q || (rd_cnt_q < vic_cnt_q) ||
                     ((rd_cnt_q == vic_cnt_q) && (rd_age > vic_age_q));

  // Clamp the capacity to the store depth
  always_comb begin
    if (CmpW'(capacity_i) > CmpW'(MAX_ENTRIES)) begin
      cap_eff = CmpW'(MAX_ENTRIES);
    end else begin
      cap_eff = CmpW'(capacity_i);
    end
  end

  assign full     = (CmpW'(occ_q) >= cap_eff);
  assign active   = cmd_i.commit && !status_o.cap_zero;
  assign do_evict = !found_q && is_put_q && full && vic_q;
  assign do_ins   = !found_q && is_put_q && (do_evict || (!full && free_q));
  assign do_wr    = active && (found_q || do_ins);
  assign cnt_inc  = (found_cnt_q == '1) ? found_cnt_q : found_cnt_q + 1'b1;

  always_comb begin
    if (found_q) begin
      wr_idx = found_idx_q;
    end else if (do_evict) begin
      wr_idx = vic_idx_q;
    end else begin
      wr_idx = free_idx_q;
    end
  end

  // Control state: scan address, flags, valid marks, touch clock
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      cmp_en_q <= 1'b0;
      found_q  <= 1'b0;
      vic_q    <= 1'b0;
      free_q   <= 1'b0;
      occ_q    <= '0;
      valid_q  <= '0;
      tclk_q   <= '0;
    end else begin
      cmp_en_q <= cmd_i.step;
      if (cmd_i.load) begin
        addr_q  <= '0;
        found_q <= 1'b0;
        vic_q   <= 1'b0;
        free_q  <= 1'b0;
        occ_q   <= '0;
      end else begin
        if (cmd_i.step) begin
          addr_q <= addr_q + 1'b1;
        end
        if (cmp_en_q) begin
          if (rd_vld_q) begin
            occ_q <= occ_q + 1'b1;
            if (key_match) begin
              found_q <= 1'b1;
            end
            vic_q <= 1'b1;
          end else begin
            free_q <= 1'b1;
          end
        end
      end
      if (do_wr) begin
        tclk_q <= tclk_q + 1'b1;
        if (do_ins) begin
          valid_q[wr_idx] <= 1'b1;
        end
      end
    end
  end

  // Request latch, read stage and scan payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      is_put_q <= action_i;
      key_q    <= req_key_i;
      val_q    <= req_value_i;
    end
    if (cmd_i.step) begin
      cmp_idx_q <= addr_q;
      rd_vld_q  <= valid_q[addr_q];
      rd_key_q  <= key_mem[addr_q];
      rd_val_q  <= val_mem[addr_q];
      rd_cnt_q  <= cnt_mem[addr_q];
      rd_tch_q  <= tch_mem[addr_q];
    end
    if (cmp_en_q && rd_vld_q) begin
      if (!found_q && key_match) begin
        found_idx_q <= cmp_idx_q;
        found_val_q <= rd_val_q;
        found_cnt_q <= rd_cnt_q;
      end
      if (vic_take) begin
        vic_idx_q <= cmp_idx_q;
        vic_key_q <= rd_key_q;
        vic_cnt_q <= rd_cnt_q;
        vic_age_q <= rd_age;
      end
    end
    if (cmp_en_q && !rd_vld_q && !free_q) begin
      free_idx_q <= cmp_idx_q;
    end
  end

  // Memory write port
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      tch_mem[wr_idx] <= tclk_q;
      cnt_mem[wr_idx] <= found_q ? cnt_inc : '0;
      if (is_put_q) begin
        val_mem[wr_idx] <= val_q;
      end
      if (!found_q) begin
        key_mem[wr_idx] <= key_q;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_o         <= active && found_q;
      read_value_o  <= (active && found_q && !is_put_q) ? found_val_q : '0;
      evicted_o     <= active && do_evict;
      evicted_key_o <= (active && do_evict) ? vic_key_q : '0;
    end
  end

endmodule

// ===== rtl/lfu_cache_with_lru_tiebreak.sv =====
// Top level of the LFU key/value cache with least-recently-touched tie-break.
//
//   channel   direction  handshake               payload
//   request   in         in_valid_i/in_stall_o   action_i, req_key_i, req_value_i
//   result    out        out_valid_o/out_stall_i hit_o, read_value_o, evicted_o,
//                                                evicted_key_o
//   config    in         APB psel/penable/pready capacity_in_use at byte address 0
//
// One request at a time: after the input transfer the block reads one entry per
// cycle (single read port), compares the last read in StLast and then commits in
// StCommit; the commit loads the result register, and the input opens again as the
// result becomes valid. At capacity 0 the scan is skipped. Reset clears valid marks, touch clock and handshake
// state at once. The input stalls from its transfer until the result is loaded; a
// held-off result parks the finished request and keeps the input stalled longer.
module lfu_cache_with_lru_tiebreak #(
  parameter int unsigned MAX_ENTRIES = lfu_pkg::MaxEntriesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic signed [lfu_pkg::KeyW-1:0] req_key_i,
  input  logic signed [lfu_pkg::ValW-1:0] req_value_i,
  // Result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           hit_o,
  output logic signed [lfu_pkg::ValW-1:0] read_value_o,
  output logic                           evicted_o,
  output logic signed [lfu_pkg::KeyW-1:0] evicted_key_o,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lfu_pkg::ApbAddrW-1:0]   paddr,
  input  logic [lfu_pkg::ApbDataW-1:0]   pwdata,
  output logic [lfu_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);

  logic [lfu_pkg::CapW-1:0] cap_q;
  logic                     cfg_wr;
  lfu_pkg::lfu_cmd_t        cmd;
  lfu_pkg::lfu_status_t     status;
  logic [lfu_pkg::ValW-1:0] read_value;
  logic [lfu_pkg::KeyW-1:0] evicted_key;

  // APB: zero wait states, register index taken from the word address
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      lfu_pkg::CfgCapacity: prdata = lfu_pkg::ApbDataW'(cap_q);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lfu_pkg::CapacityRst;
    end else if (cfg_wr && (paddr[2] == lfu_pkg::CfgCapacity)) begin
      cap_q <= pwdata[lfu_pkg::CapW-1:0];
    end
  end

  // Sequencer: owns the handshakes and steps the datapath
  lfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: entry memories, key/victim search, result register
  lfu_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .capacity_i    (cap_q),
    .action_i      (action_i),
    .req_key_i     (req_key_i),
    .req_value_i   (req_value_i),
    .hit_o         (hit_o),
    .read_value_o  (read_value),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key)
  );

  assign read_value_o  = read_value;
  assign evicted_key_o = evicted_key;

endmodule

// ===== rtl/lfu_checker.sv =====
// Port-level assertions of the LFU cache and their bind to the top level.
`include "lfu_cache_with_lru_tiebreak_macros.svh"

module lfu_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           hit_o,
  input logic signed [lfu_pkg::ValW-1:0] read_value_o,
  input logic                           evicted_o,
  input logic signed [lfu_pkg::KeyW-1:0] evicted_key_o
);

  // One request in flight: a transfer closes the input until its result is built
  `LFU_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o, "input open while busy")

  // A stalled result is not withdrawn
  `LFU_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped under stall")

  // Eviction only happens on a miss
  `LFU_ASSERT_IMPL(a_evict_miss, out_valid_o && evicted_o, !hit_o, "eviction on a hit")

  // Data fields are zero when they carry nothing
  `LFU_ASSERT_IMPL(a_zero_fields, out_valid_o && !hit_o, read_value_o == '0 && (evicted_o || evicted_key_o == '0), "stray result data")

endmodule

bind lfu_cache_with_lru_tiebreak lfu_checker u_lfu_checker (.*);
